/* hw/rtl/ray_nearest_segment_hit_unit_defines.svh */
// Assertion macros for the ray nearest segment hit unit
`ifndef RAY_NEAREST_SEGMENT_HIT_UNIT_DEFINES_SVH
`define RAY_NEAREST_SEGMENT_HIT_UNIT_DEFINES_SVH
`define RNSH_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define RNSH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

/* hw/rtl/rnsh_pkg.sv */
// Shared types and constants for the ray nearest segment hit unit
package rnsh_pkg;
    localparam int unsigned FRAC_COORD = 4;
    typedef enum logic [1:0] {
        CFG_ORIGIN_X = 2'd0,
        CFG_ORIGIN_Y = 2'd1,
        CFG_FAR_X    = 2'd2,
        CFG_FAR_Y    = 2'd3
    } t_cfg_idx;
    typedef struct packed {
        logic busy;
        logic empty;
    } t_back_status;
endpackage

/* hw/rtl/rnsh_stream_if.sv */
// Valid/ready stream interface carrying one payload
interface rnsh_stream_if #(parameter int unsigned W = 1);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/rnsh_front.sv */
// Front: segment intake, cross products and hit classification
module rnsh_front import rnsh_pkg::*; #(
    parameter int unsigned CB = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic signed [CB-1:0] i_ox,
    input  logic signed [CB-1:0] i_oy,
    input  logic signed [CB-1:0] i_fx,
    input  logic signed [CB-1:0] i_fy,
    rnsh_stream_if.sink          s_in,
    rnsh_stream_if.source        s_out
);
    localparam int unsigned DW = CB + 1;
    localparam int unsigned PW = 2 * DW + 1;
    logic signed [CB-1:0] bx, by, ex, ey;
    logic signed [DW-1:0] dax, day, dbx, dby, rx, ry;
    logic signed [PW-1:0] den, nt, nu, aden, ant, anu;
    logic                 hit, adv;
    logic                 r_v;
    logic signed [PW-1:0] r_den, r_nt;
    logic                 r_hit, r_last;

    assign {bx, by, ex, ey} = s_in.data[4*CB:1];
    assign dax = DW'(i_fx) - DW'(i_ox);
    assign day = DW'(i_fy) - DW'(i_oy);
    assign dbx = DW'(ex) - DW'(bx);
    assign dby = DW'(ey) - DW'(by);
    assign rx  = DW'(bx) - DW'(i_ox);
    assign ry  = DW'(by) - DW'(i_oy);
    assign den = PW'(dax) * PW'(dby) - PW'(day) * PW'(dbx);
    assign nt  = PW'(rx) * PW'(dby) - PW'(ry) * PW'(dbx);
    assign nu  = PW'(rx) * PW'(day) - PW'(ry) * PW'(dax);
    assign aden = den[PW-1] ? -den : den;
    assign ant  = den[PW-1] ? -nt : nt;
    assign anu  = den[PW-1] ? -nu : nu;
    assign hit = (den != '0) && (ant > 0) && (ant < aden) && (anu > 0) && (anu < aden);
    assign adv = !r_v || s_out.ready;
    assign s_in.ready = adv;
    assign s_out.valid = r_v;
    assign s_out.data = {r_den, r_nt, r_hit, r_last};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (adv) begin
            r_v <= s_in.valid;
        end
        if (adv) begin
            r_den  <= aden;
            r_nt   <= ant;
            r_hit  <= hit;
            r_last <= s_in.data[0];
        end
    end
endmodule

/* hw/rtl/rnsh_queue.sv */
// Short queue between front and back
module rnsh_queue #(
    parameter int unsigned W = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rnsh_stream_if.sink   s_in,
    rnsh_stream_if.source s_out
);
    logic [W-1:0] r_d0, r_d1;
    logic [1:0]   r_cnt;
    logic         push, pop;

    assign s_in.ready  = r_cnt != 2'd2;
    assign s_out.valid = r_cnt != 2'd0;
    assign s_out.data  = r_d0;
    assign push = s_in.valid && s_in.ready;
    assign pop  = s_out.valid && s_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
        if (pop) begin
            r_d0 <= r_d1;
            if (push && r_cnt == 2'd1) r_d0 <= s_in.data;
        end else if (push && r_cnt == 2'd0) begin
            r_d0 <= s_in.data;
        end
        if (push && ((r_cnt == 2'd1 && !pop) || (r_cnt == 2'd2))) r_d1 <= s_in.data;
    end
endmodule

/* hw/rtl/rnsh_back.sv */
// Back: serial divide, running minimum and hit point output
module rnsh_back import rnsh_pkg::*; #(
    parameter int unsigned CB = 16,
    parameter int unsigned TF = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic signed [CB-1:0] i_ox,
    input  logic signed [CB-1:0] i_oy,
    input  logic signed [CB-1:0] i_fx,
    input  logic signed [CB-1:0] i_fy,
    rnsh_stream_if.sink          s_in,
    rnsh_stream_if.source        s_out,
    output t_back_status         o_status
);
    localparam int unsigned DW = CB + 1;
    localparam int unsigned PW = 2 * DW + 1;
    localparam int unsigned TW = TF + 1;
    localparam int unsigned MW = DW + TW + 1;
    localparam int unsigned CW = $clog2(TF + 1);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_MULT = 4'b0100,
        ST_OUT  = 4'b1000
    } t_state;

    t_state              r_st;
    logic [PW-1:0]       r_den, r_rem;
    logic [TF-1:0]       r_q;
    logic [CW-1:0]       r_cnt;
    logic                r_last;
    logic [TW-1:0]       r_best;
    logic signed [MW-1:0] r_px, r_py;
    logic signed [CB-1:0] r_hx, r_hy;
    logic [TW-1:0]       r_ot;
    logic                r_ov;
    logic signed [PW-1:0] s_den, s_nt;
    logic                s_hit, s_last;
    logic [PW:0]         rem2;
    logic signed [DW-1:0] dxr, dyr;

    assign {s_den, s_nt, s_hit, s_last} = s_in.data;
    assign s_in.ready = (r_st == ST_IDLE);
    assign rem2 = {r_rem, 1'b0};
    assign dxr = DW'(i_fx) - DW'(i_ox);
    assign dyr = DW'(i_fy) - DW'(i_oy);
    assign s_out.valid = r_ov;
    assign s_out.data = {r_hx, r_hy, r_ot, !r_ot[TF]};
    assign o_status.busy = r_st != ST_IDLE;
    assign o_status.empty = !r_ov;

    function automatic logic signed [CB-1:0] fin(input logic signed [MW-1:0] p,
                                                 input logic signed [CB-1:0] o);
        logic signed [MW:0] v, hi, lo;
        hi = $signed((MW+1)'({1'b0, {(CB-1){1'b1}}}));
        lo = -hi - (MW+1)'(1);
        v = (MW+1)'(o) + (MW+1)'((p + (MW'(1) <<< (TF-1))) >>> TF);
        if (v > hi) return {1'b0, {(CB-1){1'b1}}};
        if (v < lo) return {1'b1, {(CB-1){1'b0}}};
        return v[CB-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= ST_IDLE;
            r_best <= TW'(1) << TF;
            r_ov   <= 1'b0;
        end else begin
            if (s_out.ready && r_st != ST_OUT) r_ov <= 1'b0;
            unique case (r_st)
                ST_IDLE: begin
                    if (s_in.valid) begin
                        r_den  <= s_den;
                        r_rem  <= s_nt;
                        r_q    <= '0;
                        r_cnt  <= '0;
                        r_last <= s_last;
                        if (s_hit) r_st <= ST_DIV;
                        else if (s_last) r_st <= ST_MULT;
                    end
                end
                ST_DIV: begin
                    if (rem2 >= {1'b0, r_den}) begin
                        r_rem <= PW'(rem2 - {1'b0, r_den});
                        r_q   <= {r_q[TF-2:0], 1'b1};
                    end else begin
                        r_rem <= PW'(rem2);
                        r_q   <= {r_q[TF-2:0], 1'b0};
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CW'(TF - 1)) r_st <= ST_MULT;
                end
                ST_MULT: begin
                    if (r_cnt == CW'(TF) && r_q < r_best) begin
                        r_best <= TW'(r_q);
                    end
                    r_cnt <= '0;
                    if (r_last) begin
                        r_px <= MW'(dxr) * $signed({1'b0, (r_cnt == CW'(TF) && r_q < r_best)
                                ? TW'(r_q) : r_best});
                        r_py <= MW'(dyr) * $signed({1'b0, (r_cnt == CW'(TF) && r_q < r_best)
                                ? TW'(r_q) : r_best});
                        r_st <= ST_OUT;
                    end else begin
                        r_st <= ST_IDLE;
                    end
                end
                ST_OUT: begin
                    if (!r_ov || s_out.ready) begin
                        r_hx   <= fin(r_px, i_ox);
                        r_hy   <= fin(r_py, i_oy);
                        r_ot   <= r_best;
                        r_ov   <= 1'b1;
                        r_best <= TW'(1) << TF;
                        r_st   <= ST_IDLE;
                    end
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end
endmodule

/* hw/rtl/ray_nearest_segment_hit_unit.sv */
// Ray nearest segment hit unit: 2D ray cast against a stream of segments.
// Path: a last segment that misses passes the front register, the queue, the back accept,
// the multiply and the output register; a hit also passes the divider before the multiply.
// Throughput: one segment per cycle for misses that are not last, while the back is idle;
// a hit busies the back's restoring divider. A two entry queue decouples front and back.
// Synchronous active-low reset clears control, ray registers and sets the minimum to one.
`include "ray_nearest_segment_hit_unit_defines.svh"
module ray_nearest_segment_hit_unit import rnsh_pkg::*; #(
    parameter int unsigned COORD_BITS  = 16,
    parameter int unsigned T_FRAC_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_idx,
    input  logic [COORD_BITS-1:0] i_cfg_data,
    rnsh_stream_if.sink           s_in,
    rnsh_stream_if.source         s_out
);
    localparam int unsigned PW = 2 * (COORD_BITS + 1) + 1;
    localparam int unsigned QW = 2 * PW + 2;

    logic signed [COORD_BITS-1:0] r_ox, r_oy, r_fx, r_fy;
    t_back_status bst;

    rnsh_stream_if #(.W(QW)) f2q ();
    rnsh_stream_if #(.W(QW)) q2b ();

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ox <= '0; r_oy <= '0; r_fx <= '0; r_fy <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_ORIGIN_X: r_ox <= i_cfg_data;
                CFG_ORIGIN_Y: r_oy <= i_cfg_data;
                CFG_FAR_X:    r_fx <= i_cfg_data;
                CFG_FAR_Y:    r_fy <= i_cfg_data;
                default:      r_ox <= r_ox;
            endcase
        end
    end

    rnsh_front #(.CB(COORD_BITS)) u_front (
        .i_clk, .i_rst_n, .i_ox(r_ox), .i_oy(r_oy), .i_fx(r_fx), .i_fy(r_fy),
        .s_in(s_in), .s_out(f2q)
    );
    rnsh_queue #(.W(QW)) u_queue (.i_clk, .i_rst_n, .s_in(f2q), .s_out(q2b));
    rnsh_back #(.CB(COORD_BITS), .TF(T_FRAC_BITS)) u_back (
        .i_clk, .i_rst_n, .i_ox(r_ox), .i_oy(r_oy), .i_fx(r_fx), .i_fy(r_fy),
        .s_in(q2b), .s_out(s_out), .o_status(bst)
    );

    `RNSH_ASSERT_IMPL(a_flag_t, i_clk, i_rst_n, s_out.valid, s_out.data[0] == !s_out.data[T_FRAC_BITS+1])
    `RNSH_ASSERT_IMPL(a_idle_out, i_clk, i_rst_n, !bst.busy && q2b.valid, q2b.ready)
    `RNSH_ASSERT_NEXT(a_hold, i_clk, i_rst_n, s_out.valid && !s_out.ready, s_out.valid)
endmodule
